>>> hdl/mmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_pkg
// shared types and constants of the magnetometer min/max calibrator
// ----------------------------------------------------------------------------
package mmc_pkg;
  localparam int AxisW = 16;
  localparam int FieldW = 17;
  localparam int OffW = 10;
  localparam int GainW = 16;
  localparam int CntW = 16;
  localparam int SpanW = 10;
  localparam int DivSteps = 24;
  localparam int StepW = 5;
  localparam logic signed [AxisW-1:0] LimitMag = 16'sd400;
  localparam logic signed [AxisW-1:0] MaxReset = -16'sd100;
  localparam logic signed [AxisW-1:0] MinReset = 16'sd100;
  localparam logic signed [OffW-1:0] OffReset = -10'sd1;
  localparam logic [GainW-1:0] GainYReset = 16'd3497;
  localparam logic [GainW-1:0] GainZReset = 16'd3846;
  localparam logic [CntW-1:0] CalReset = 16'd1000;
  localparam logic [GainW-1:0] GainSat = 16'hffff;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPDATE, ST_DIV_Y, ST_DIV_Z, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic div_start_y;
    logic div_start_z;
    logic div_step;
    logic store_y;
    logic store_z;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic div_last;
  } stat_t;
endpackage
`default_nettype wire

>>> hdl/mmc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_in_if / mmc_out_if
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
interface mmc_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] reg_x_word;
  logic signed [15:0] reg_y_word;
  logic signed [15:0] reg_z_word;
  logic start_calibration;
  modport source (output valid, reg_x_word, reg_y_word, reg_z_word, start_calibration,
                  input ready);
  modport sink (input valid, reg_x_word, reg_y_word, reg_z_word, start_calibration,
                output ready);
endinterface

interface mmc_out_if;
  logic valid;
  logic ready;
  logic signed [16:0] field_x;
  logic signed [16:0] field_y;
  logic signed [16:0] field_z;
  logic signed [9:0] offset_x_out;
  logic signed [9:0] offset_y_out;
  logic signed [9:0] offset_z_out;
  logic [15:0] gain_y_out;
  logic [15:0] gain_z_out;
  logic calibrating_out;
  logic calibration_done;
  modport source (output valid, field_x, field_y, field_z, offset_x_out, offset_y_out,
                  offset_z_out, gain_y_out, gain_z_out, calibrating_out,
                  calibration_done, input ready);
  modport sink (input valid, field_x, field_y, field_z, offset_x_out, offset_y_out,
                offset_z_out, gain_y_out, gain_z_out, calibrating_out,
                calibration_done, output ready);
endinterface
`default_nettype wire

>>> hdl/magnetometer_minmax_calibrator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrator_unit
// hard-iron min/max calibrator with span-ratio gains
// a completing item also runs two 24-step gain divisions before its result is loaded
// a new item is taken only after the previous result has been handed off
// reset: synchronous, restores offsets, gains, bounds and cal_samples
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibrator_unit import mmc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  mmc_in_if.sink           in_ch,
  mmc_out_if.source        out_ch
);
  cmd_t cmd;
  stat_t stat;
  logic out_busy;
  logic signed [FieldW-1:0] res_field [3];
  logic signed [OffW-1:0] res_off [3];
  logic [GainW-1:0] res_gain_y, res_gain_z;
  logic res_cal, res_done;

  assign out_busy = out_ch.valid && !out_ch.ready;

  mmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_busy), .stat(stat), .cmd(cmd)
  );

  mmc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_x(in_ch.reg_x_word), .in_y(in_ch.reg_y_word), .in_z(in_ch.reg_z_word),
    .in_start(in_ch.start_calibration), .res_field(res_field), .res_off(res_off),
    .res_gain_y(res_gain_y), .res_gain_z(res_gain_z), .res_cal(res_cal),
    .res_done(res_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.field_x <= res_field[0];
      out_ch.field_y <= res_field[1];
      out_ch.field_z <= res_field[2];
      out_ch.offset_x_out <= res_off[0];
      out_ch.offset_y_out <= res_off[1];
      out_ch.offset_z_out <= res_off[2];
      out_ch.gain_y_out <= res_gain_y;
      out_ch.gain_z_out <= res_gain_z;
      out_ch.calibrating_out <= res_cal;
      out_ch.calibration_done <= res_done;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !cmd.div_step) else $error("item taken during division");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.calibration_done) |-> !out_ch.calibrating_out)
    else $error("done while calibrating");
  a_store_once: assert property (@(posedge clk) disable iff (rst)
    !(cmd.store_y && cmd.store_z)) else $error("both gains stored at once");
endmodule
`default_nettype wire

>>> hdl/mmc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_ctrl
// sequencer: accept, update, two gain divisions on a completing item, result hand-off
// ----------------------------------------------------------------------------
module mmc_ctrl import mmc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  out_busy,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = stat.complete ? ST_DIV_Y : ST_OUT;
      end
      ST_DIV_Y: begin
        if (stat.div_last) state_next = ST_DIV_Z;
      end
      ST_DIV_Z: begin
        if (stat.div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.div_start_y = stat.complete;
      end
      ST_DIV_Y: begin
        cmd.div_step = 1'b1;
        cmd.store_y = stat.div_last;
        cmd.div_start_z = stat.div_last;
      end
      ST_DIV_Z: begin
        cmd.div_step = 1'b1;
        cmd.store_z = stat.div_last;
      end
      ST_OUT: begin
        cmd.out_load = !out_busy;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/mmc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_datapath
// axis remap, min/max tracking, offsets and restoring gain divider
// ----------------------------------------------------------------------------
module mmc_datapath import mmc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output stat_t                         stat,
  input  wire logic                     cfg_we,
  input  wire logic [CntW-1:0]          cfg_data,
  input  wire logic signed [AxisW-1:0]  in_x,
  input  wire logic signed [AxisW-1:0]  in_y,
  input  wire logic signed [AxisW-1:0]  in_z,
  input  wire logic                     in_start,
  output logic signed [FieldW-1:0]      res_field [3],
  output logic signed [OffW-1:0]        res_off [3],
  output logic [GainW-1:0]              res_gain_y,
  output logic [GainW-1:0]              res_gain_z,
  output logic                          res_cal,
  output logic                          res_done
);
  logic [CntW-1:0] cal_samples;
  logic signed [AxisW-1:0] axis [3];
  logic signed [AxisW-1:0] axis_max [3];
  logic signed [AxisW-1:0] axis_min [3];
  logic signed [AxisW-1:0] max_next [3];
  logic signed [AxisW-1:0] min_next [3];
  logic signed [OffW-1:0] axis_offset [3];
  logic [GainW-1:0] gain_y, gain_z;
  logic [CntW-1:0] counter;
  logic calibrating, cal_eff, in_range, done;
  logic start_r;
  logic signed [FieldW-1:0] field [3];
  logic [SpanW-1:0] span [3];
  logic signed [AxisW:0] sum [3];
  // divider
  logic [SpanW-1:0] div_den;
  logic div_zero;
  logic [DivSteps-1:0] div_num;
  logic [SpanW:0] div_rem;
  logic [DivSteps-1:0] div_q;
  logic [StepW-1:0] div_cnt;
  logic [SpanW+1:0] rem_shift;
  logic [SpanW+1:0] rem_sub;
  logic [DivSteps-1:0] q_fin;
  logic [GainW-1:0] gain_res;
  logic [DivSteps:0] q_round;

  assign cal_eff = calibrating | start_r;
  assign stat.div_last = (div_cnt == StepW'(DivSteps - 1));

  always_comb begin
    in_range = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (axis[i] >= LimitMag || axis[i] <= -LimitMag) in_range = 1'b0;
      max_next[i] = (axis[i] > axis_max[i]) ? axis[i] : axis_max[i];
      min_next[i] = (axis[i] < axis_min[i]) ? axis[i] : axis_min[i];
      sum[i] = {max_next[i][AxisW-1], max_next[i]} + {min_next[i][AxisW-1], min_next[i]};
      span[i] = SpanW'(max_next[i] - min_next[i]);
    end
  end

  assign stat.complete = cal_eff && in_range && (counter == cal_samples);

  always_comb begin
    rem_shift = {div_rem, div_num[DivSteps-1]};
    rem_sub = rem_shift - {2'b00, div_den};
    q_fin = {div_q[DivSteps-2:0], !rem_sub[SpanW+1]};
    q_round = {1'b0, q_fin} + 1'b1;
    if (div_zero || q_round[DivSteps:1] > {{(DivSteps-GainW){1'b0}}, GainSat}) begin
      gain_res = GainSat;
    end else begin
      gain_res = GainW'(q_round[DivSteps:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CalReset;
      gain_y <= GainYReset;
      gain_z <= GainZReset;
      counter <= '0;
      calibrating <= 1'b0;
      done <= 1'b0;
      start_r <= 1'b0;
      div_cnt <= '0;
      for (int i = 0; i < 3; i++) begin
        axis_max[i] <= MaxReset;
        axis_min[i] <= MinReset;
        axis_offset[i] <= OffReset;
      end
    end else begin
      if (cfg_we) cal_samples <= cfg_data;
      if (cmd.load) begin
        axis[0] <= in_y;
        axis[1] <= in_x;
        axis[2] <= -in_z;
        start_r <= in_start;
        done <= 1'b0;
      end
      if (cmd.update) begin
        for (int i = 0; i < 3; i++) begin
          field[i] <= FieldW'(axis[i]) - FieldW'(axis_offset[i]);
        end
        if (cal_eff) begin
          counter <= stat.complete ? CntW'(1) : counter + 1'b1;
          calibrating <= !stat.complete;
          if (in_range) begin
            for (int i = 0; i < 3; i++) begin
              axis_max[i] <= max_next[i];
              axis_min[i] <= min_next[i];
            end
          end
          if (stat.complete) begin
            done <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              axis_offset[i] <= OffW'(sum[i] / 2);
            end
          end
        end
      end
      if (cmd.div_start_y || cmd.div_start_z) begin
        div_num <= DivSteps'({span[0], 13'd0}) ;
        div_rem <= '0;
        div_q <= '0;
        div_cnt <= '0;
        div_den <= cmd.div_start_y ? span[1] : span[2];
        div_zero <= cmd.div_start_y ? (span[1] == '0) : (span[2] == '0);
      end else if (cmd.div_step) begin
        div_num <= {div_num[DivSteps-2:0], 1'b0};
        div_cnt <= div_cnt + 1'b1;
        if (!rem_sub[SpanW+1]) begin
          div_rem <= rem_sub[SpanW:0];
          div_q <= {div_q[DivSteps-2:0], 1'b1};
        end else begin
          div_rem <= rem_shift[SpanW:0];
          div_q <= {div_q[DivSteps-2:0], 1'b0};
        end
      end
      if (cmd.store_y) gain_y <= gain_res;
      if (cmd.store_z) gain_z <= gain_res;
    end
  end

  // the quotient shown to gain_res includes the bit of the current step, so store uses
  // the combinational result of the last step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_field[i] = field[i];
      res_off[i] = axis_offset[i];
    end
    res_gain_y = gain_y;
    res_gain_z = gain_z;
    res_cal = calibrating;
    res_done = done;
  end
endmodule
`default_nettype wire

>>> sim/magnetometer_minmax_calibrator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrator_unit_tb
// drives sensor samples through the calibrator under random stalls, predicts
// remapped fields, offsets, gains and completion flags, and checks every item
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibrator_unit_tb;
  import mmc_pkg::*;

  typedef struct {
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
    logic start;
  } sample_t;

  typedef struct {
    logic signed [16:0] fx, fy, fz;
    logic signed [9:0] ox, oy, oz;
    logic [15:0] gy, gz;
    logic cal, done;
  } field_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_taken = 1'b0;

  mmc_in_if in_ch ();
  mmc_out_if out_ch ();

  magnetometer_minmax_calibrator_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  sample_t pending_samples[$];
  field_t expected_fields[$];
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;

  // calibrator state mirror
  int unsigned cal_target;
  int bound_max[3], bound_min[3], offs[3];
  int unsigned gain_y, gain_z, sample_cnt;
  bit calibrating;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.reg_x_word = '0;
    in_ch.reg_y_word = '0;
    in_ch.reg_z_word = '0;
    in_ch.start_calibration = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned span_ratio(int num, int den);
    longint unsigned q;
    if (den <= 0 || num < 0) return 65535;
    q = (longint'(num) * 8192 + den) / (2 * den);
    return (q > 65535) ? 65535 : int'(q);
  endfunction

  task automatic calibrate_sample(input sample_t s);
    int ax[3];
    field_t r;
    bit in_range, done;
    done = 1'b0;
    ax[0] = s.wy;
    ax[1] = s.wx;
    ax[2] = $signed(16'(-s.wz));
    r.fx = 17'(ax[0] - offs[0]);
    r.fy = 17'(ax[1] - offs[1]);
    r.fz = 17'(ax[2] - offs[2]);
    if (s.start) calibrating = 1'b1;
    if (calibrating) begin
      in_range = 1'b1;
      for (int i = 0; i < 3; i++)
        if (ax[i] >= 400 || ax[i] <= -400) in_range = 1'b0;
      if (in_range) begin
        for (int i = 0; i < 3; i++) begin
          if (ax[i] > bound_max[i]) bound_max[i] = ax[i];
          if (ax[i] < bound_min[i]) bound_min[i] = ax[i];
        end
        if (sample_cnt == cal_target) begin
          for (int i = 0; i < 3; i++) offs[i] = (bound_max[i] + bound_min[i]) / 2;
          gain_y = span_ratio(bound_max[0] - bound_min[0], bound_max[1] - bound_min[1]);
          gain_z = span_ratio(bound_max[0] - bound_min[0], bound_max[2] - bound_min[2]);
          sample_cnt = 0;
          calibrating = 1'b0;
          done = 1'b1;
        end
      end
      sample_cnt = (sample_cnt + 1) & 16'hffff;
    end
    r.ox = 10'(offs[0]);
    r.oy = 10'(offs[1]);
    r.oz = 10'(offs[2]);
    r.gy = 16'(gain_y);
    r.gz = 16'(gain_z);
    r.cal = calibrating;
    r.done = done;
    expected_fields.push_back(r);
  endtask

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  // input handshake seen at the rising edge, used by the driver
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // prediction and checking at the rising edge
  always @(posedge clk) begin
    field_t e;
    sample_t s;
    if (rst) begin
      cal_target = CalReset;
      for (int i = 0; i < 3; i++) begin
        bound_max[i] = -100;
        bound_min[i] = 100;
        offs[i] = -1;
      end
      gain_y = GainYReset;
      gain_z = GainZReset;
      sample_cnt = 0;
      calibrating = 1'b0;
    end else begin
      if (cfg_we) cal_target = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        s.wx = in_ch.reg_x_word;
        s.wy = in_ch.reg_y_word;
        s.wz = in_ch.reg_z_word;
        s.start = in_ch.start_calibration;
        calibrate_sample(s);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_fields.size() == 0) begin
          $error("unexpected item on output");
          errors++;
        end else begin
          e = expected_fields.pop_front();
          check_field("field_x", e.fx, out_ch.field_x);
          check_field("field_y", e.fy, out_ch.field_y);
          check_field("field_z", e.fz, out_ch.field_z);
          check_field("offset_x_out", e.ox, out_ch.offset_x_out);
          check_field("offset_y_out", e.oy, out_ch.offset_y_out);
          check_field("offset_z_out", e.oz, out_ch.offset_z_out);
          check_field("gain_y_out", e.gy, out_ch.gain_y_out);
          check_field("gain_z_out", e.gz, out_ch.gain_z_out);
          check_field("calibrating_out", e.cal, out_ch.calibrating_out);
          check_field("calibration_done", e.done, out_ch.calibration_done);
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    sample_t s;
    if (!rst && (!in_ch.valid || in_taken)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        s = pending_samples.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.reg_x_word <= s.wx;
        in_ch.reg_y_word <= s.wy;
        in_ch.reg_z_word <= s.wz;
        in_ch.start_calibration <= s.start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic add_sample(input int x, input int y, input int z, input bit st);
    sample_t s;
    s.wx = 16'(x);
    s.wy = 16'(y);
    s.wz = 16'(z);
    s.start = st;
    pending_samples.push_back(s);
  endtask

  task automatic add_random_samples(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 92)
        add_sample($urandom_range(798) - 399, $urandom_range(798) - 399,
                   $urandom_range(798) - 399, $urandom_range(29) == 0);
      else
        add_sample($urandom, $urandom, $urandom, $urandom_range(1));
    end
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || in_ch.valid || expected_fields.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cal(input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= 16'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // keep the target reachable from where the counter stands
  task automatic write_reachable_cal(input int unsigned k);
    write_cal((sample_cnt > k) ? ((sample_cnt + 2) & 16'hffff) : k);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // completion on the very first in-range sample, zero spans saturate gains
    write_cal(0);
    add_sample(32767, -32768, 0, 1'b0);
    add_sample(-32768, 32767, -32768, 1'b0);
    add_sample(10, 20, 30, 1'b1);
    add_sample(-1, -1, -1, 1'b0);
    add_sample(0, 0, -32768, 1'b1);
    add_sample(399, -399, 399, 1'b1);
    add_sample(-399, 399, -399, 1'b0);
    add_sample(400, 0, 0, 1'b0);
    add_sample(0, -400, 0, 1'b0);
    add_sample(0, 0, 400, 1'b0);
    add_sample(32767, 32767, 32767, 1'b0);
    add_sample(-32768, -32768, 1, 1'b1);
    drain();
    write_reachable_cal(4);
    add_sample(100, 150, 200, 1'b1);
    add_sample(-150, -200, -50, 1'b0);
    add_sample(300, -300, 250, 1'b0);
    add_sample(-250, 250, -300, 1'b0);
    add_sample(50, 60, 70, 1'b0);
    add_sample(5, 5, 5, 1'b0);
    add_sample(-5, 7, 9, 1'b0);
    drain();

    sender_idle_pct = 33;
    receiver_idle_pct = 68;
    write_reachable_cal(3);
    add_random_samples(650);
    drain();

    sender_idle_pct = 68;
    receiver_idle_pct = 33;
    write_reachable_cal(17);
    add_random_samples(650);
    drain();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_reachable_cal(1);
    add_random_samples(500);
    repeat (200) @(posedge clk);
    hold_cycles = 400;
    drain();

    write_cal(65535);
    add_random_samples(100);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> filelist.f
hdl/mmc_pkg.sv
hdl/mmc_if.sv
hdl/mmc_ctrl.sv
hdl/mmc_datapath.sv
hdl/magnetometer_minmax_calibrator_unit.sv
sim/magnetometer_minmax_calibrator_unit_tb.sv
